// File: hw/rtl/nearest_grid_pixel_index_assert.svh
// assertion macros for the nearest grid pixel index block
`ifndef NEAREST_GRID_PIXEL_INDEX_ASSERT_SVH
`define NEAREST_GRID_PIXEL_INDEX_ASSERT_SVH
// implication checked on every clock edge outside reset
`define NGPI_ASSERT_IMP(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("ngpi check failed");
// next-cycle implication
`define NGPI_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("ngpi check failed");
`endif

// File: hw/rtl/ngpi_pkg.sv
// shared types, constants and widths for the nearest grid pixel index block
package ngpi_pkg;
    localparam int unsigned MAX_COLS_DEF = 4096;
    localparam int unsigned MAX_ROWS_DEF = 4096;
    localparam int unsigned QW = 34;
    localparam int unsigned NUM_W = 35;
    localparam int unsigned DEN_W = 32;
    localparam int unsigned CNT_W = 3;
    localparam logic [CNT_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CNT_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CNT_W-1:0] REG_STEP_X = 3'd2;
    localparam logic [CNT_W-1:0] REG_STEP_Y = 3'd3;
    localparam logic [CNT_W-1:0] REG_GRID_COLS = 3'd4;
    localparam logic [CNT_W-1:0] REG_GRID_ROWS = 3'd5;
    localparam logic [CNT_W-1:0] REG_TOL_SQ = 3'd6;
    localparam logic [CNT_W-1:0] REG_TOL_ON = 3'd7;

    typedef struct packed {
        logic signed [32:0] ddx;
        logic signed [32:0] ddy;
        logic               last;
    } side_t;
endpackage

// File: hw/rtl/nearest_grid_pixel_index.sv
// top level: nearest grid pixel lookup with a pipelined divider chain
// registered stages from start to result strobe: stage 0, stage 1, the divider cells, stages a to d
// throughput: one request per cycle, busy is held low
// the divider chain of 2-bit cells sets the latency
// reset clears the registers to their defaults and empties the pipeline
module nearest_grid_pixel_index #(
    parameter int unsigned MAX_COLS = ngpi_pkg::MAX_COLS_DEF,
    parameter int unsigned MAX_ROWS = ngpi_pkg::MAX_ROWS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic               last_point,
    output logic               result_valid,
    output logic [23:0]        pixel_index,
    output logic               inside_res,
    output logic               last_out
);
    import ngpi_pkg::*;

    `include "nearest_grid_pixel_index_assert.svh"

    localparam int unsigned NCELL = (QW + 1) / 2;
    localparam int unsigned CW = $clog2(MAX_COLS + 1);
    localparam int unsigned RWD = $clog2(MAX_ROWS + 1);

    logic signed [31:0] origin_x_reg, origin_y_reg;
    logic [30:0]        step_x_reg, step_y_reg;
    logic [12:0]        grid_cols_reg, grid_rows_reg;
    logic [63:0]        tolerance_sq_reg;
    logic               tolerance_on_reg;
    logic               wr_en;
    logic [CNT_W-1:0]   wr_idx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign wr_en  = psel & penable & pwrite;
    assign wr_idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            step_x_reg       <= 31'd65536;
            step_y_reg       <= 31'd65536;
            grid_cols_reg    <= 13'd1;
            grid_rows_reg    <= 13'd1;
            tolerance_sq_reg <= '0;
            tolerance_on_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                REG_ORIGIN_X:  origin_x_reg     <= pwdata[31:0];
                REG_ORIGIN_Y:  origin_y_reg     <= pwdata[31:0];
                REG_STEP_X:    step_x_reg       <= pwdata[30:0];
                REG_STEP_Y:    step_y_reg       <= pwdata[30:0];
                REG_GRID_COLS: grid_cols_reg    <= pwdata[12:0];
                REG_GRID_ROWS: grid_rows_reg    <= pwdata[12:0];
                REG_TOL_SQ:    tolerance_sq_reg <= pwdata;
                REG_TOL_ON:    tolerance_on_reg <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (wr_idx)
            REG_ORIGIN_X:  prdata = {32'd0, origin_x_reg};
            REG_ORIGIN_Y:  prdata = {32'd0, origin_y_reg};
            REG_STEP_X:    prdata = {33'd0, step_x_reg};
            REG_STEP_Y:    prdata = {33'd0, step_y_reg};
            REG_GRID_COLS: prdata = {51'd0, grid_cols_reg};
            REG_GRID_ROWS: prdata = {51'd0, grid_rows_reg};
            REG_TOL_SQ:    prdata = tolerance_sq_reg;
            default:       prdata = {63'd0, tolerance_on_reg};
        endcase
    end

    logic [30:0] sx, sy;
    assign sx = (step_x_reg == '0) ? 31'd1 : step_x_reg;
    assign sy = (step_y_reg == '0) ? 31'd1 : step_y_reg;

    // stage 0: offsets and signed numerators n = 2*dd + s
    logic              s0_vld;
    side_t             s0_side;
    logic signed [34:0] s0_nx, s0_ny;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s0_vld <= 1'b0;
        else        s0_vld <= start;
    end
    always_ff @(posedge clk)
    begin
        s0_side.ddx  <= 33'(point_x) - 33'(origin_x_reg);
        s0_side.ddy  <= 33'(point_y) - 33'(origin_y_reg);
        s0_side.last <= last_point;
        s0_nx <= 35'(2 * (35'(point_x) - 35'(origin_x_reg))) + 35'(sx);
        s0_ny <= 35'(2 * (35'(point_y) - 35'(origin_y_reg))) + 35'(sy);
    end

    // stage 1: magnitudes for unsigned division
    logic              s1_vld;
    side_t             s1_side;
    logic [NUM_W-1:0]  s1_ax, s1_ay;
    logic              s1_sgx, s1_sgy;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s1_vld <= 1'b0;
        else        s1_vld <= s0_vld;
    end
    always_ff @(posedge clk)
    begin
        s1_side <= s0_side;
        s1_sgx  <= s0_nx[34];
        s1_sgy  <= s0_ny[34];
        s1_ax   <= s0_nx[34] ? NUM_W'(-s0_nx) : NUM_W'(s0_nx);
        s1_ay   <= s0_ny[34] ? NUM_W'(-s0_ny) : NUM_W'(s0_ny);
    end

    // divider chain: quotient bits generated msb first, numerator shifted in
    logic             c_vld [NCELL+1];
    logic [NUM_W-1:0] c_rx [NCELL+1];
    logic [NUM_W-1:0] c_ry [NCELL+1];
    logic [QW-1:0]    c_qx [NCELL+1];
    logic [QW-1:0]    c_qy [NCELL+1];
    logic [DEN_W-1:0] c_dx [NCELL+1];
    logic [DEN_W-1:0] c_dy [NCELL+1];
    logic             c_nx [NCELL+1];
    logic             c_ny [NCELL+1];
    side_t            c_sd [NCELL+1];

    assign c_vld[0] = s1_vld;
    assign c_rx[0]  = '0;
    assign c_ry[0]  = '0;
    assign c_qx[0]  = QW'(s1_ax);
    assign c_qy[0]  = QW'(s1_ay);
    assign c_dx[0]  = {sx, 1'b0};
    assign c_dy[0]  = {sy, 1'b0};
    assign c_nx[0]  = s1_sgx;
    assign c_ny[0]  = s1_sgy;
    assign c_sd[0]  = s1_side;

    genvar g;
    generate
        for (g = 0; g < NCELL; g++)
        begin : g_cell
            ngpi_div_cell u_cell (
                .clk(clk), .rst_n(rst_n),
                .vld_in(c_vld[g]), .rx_in(c_rx[g]), .ry_in(c_ry[g]),
                .qx_in(c_qx[g]), .qy_in(c_qy[g]),
                .dx_in(c_dx[g]), .dy_in(c_dy[g]),
                .nx_in(c_nx[g]), .ny_in(c_ny[g]), .side_in(c_sd[g]),
                .vld_out(c_vld[g+1]), .rx_out(c_rx[g+1]), .ry_out(c_ry[g+1]),
                .qx_out(c_qx[g+1]), .qy_out(c_qy[g+1]),
                .dx_out(c_dx[g+1]), .dy_out(c_dy[g+1]),
                .nx_out(c_nx[g+1]), .ny_out(c_ny[g+1]), .side_out(c_sd[g+1])
            );
        end
    endgenerate

    // stage a: floor correction
    logic              a_vld;
    side_t             a_side;
    logic signed [35:0] a_col, a_qy;
    logic signed [35:0] qxs, qys;
    always_comb
    begin
        qxs = $signed({2'b00, c_qx[NCELL]});
        qys = $signed({2'b00, c_qy[NCELL]});
        if (c_nx[NCELL]) qxs = -qxs - ((c_rx[NCELL] != '0) ? 36'sd1 : 36'sd0);
        if (c_ny[NCELL]) qys = -qys - ((c_ry[NCELL] != '0) ? 36'sd1 : 36'sd0);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) a_vld <= 1'b0;
        else        a_vld <= c_vld[NCELL];
    end
    always_ff @(posedge clk)
    begin
        a_side <= c_sd[NCELL];
        a_col  <= qxs;
        a_qy   <= qys;
    end

    // stage b: residuals and range checks; quotients stay small so 36x31 products
    logic              b_vld, b_last, b_inr;
    logic signed [33:0] b_rx, b_ry;
    logic [CW-1:0]     b_col;
    logic [RWD-1:0]    b_row;
    logic [CW-1:0]     cols_c;
    logic [RWD-1:0]    rows_c;
    logic signed [37:0] row_s;
    logic signed [67:0] px_m, py_m;
    assign cols_c = (32'(grid_cols_reg) > MAX_COLS) ? CW'(MAX_COLS) : CW'(grid_cols_reg);
    assign rows_c = (32'(grid_rows_reg) > MAX_ROWS) ? RWD'(MAX_ROWS) : RWD'(grid_rows_reg);
    assign row_s  = 38'(rows_c) - 38'sd1 - 38'(a_qy);
    assign px_m   = a_col * $signed({1'b0, sx});
    assign py_m   = a_qy * $signed({1'b0, sy});
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) b_vld <= 1'b0;
        else        b_vld <= a_vld;
    end
    always_ff @(posedge clk)
    begin
        b_last <= a_side.last;
        b_rx   <= 34'(68'(a_side.ddx) - px_m);
        b_ry   <= 34'(68'(a_side.ddy) - py_m);
        b_inr  <= (a_col >= 0) && (a_col < 36'(cols_c)) && (row_s >= 0)
                  && (row_s < 38'(rows_c)) && (cols_c != '0) && (rows_c != '0);
        b_col  <= CW'(a_col);
        b_row  <= RWD'(row_s);
    end

    // stage c: squares and index product
    logic              q_vld, q_last, q_inr;
    logic [63:0]       q_a, q_b;
    logic [23:0]       q_idx;
    logic [33:0]       abx, aby;
    assign abx = b_rx[33] ? 34'(-b_rx) : 34'(b_rx);
    assign aby = b_ry[33] ? 34'(-b_ry) : 34'(b_ry);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) q_vld <= 1'b0;
        else        q_vld <= b_vld;
    end
    always_ff @(posedge clk)
    begin
        q_last <= b_last;
        q_inr  <= b_inr;
        q_a    <= 64'(abx[31:0]) * 64'(abx[31:0]);
        q_b    <= 64'(aby[31:0]) * 64'(aby[31:0]);
        q_idx  <= 24'(32'(b_row) * 32'(cols_c) + 32'(b_col));
    end

    // stage d: tolerance compare and output register
    logic [64:0] d2;
    logic        incl;
    logic        r_vld_reg;
    assign d2   = 65'(q_a) + 65'(q_b);
    assign incl = !tolerance_on_reg || (d2[64] ? 1'b0 : (d2[63:0] <= tolerance_sq_reg))
                  || (d2[64] && tolerance_sq_reg == '1);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) r_vld_reg <= 1'b0;
        else        r_vld_reg <= q_vld;
    end
    always_ff @(posedge clk)
    begin
        last_out    <= q_last;
        inside_res  <= q_inr & incl;
        pixel_index <= (q_inr & incl) ? q_idx : '0;
    end
    assign result_valid = r_vld_reg;

    `NGPI_ASSERT_NEXT(a_strobe_follows, q_vld, result_valid)
    `NGPI_ASSERT_IMP(a_zero_when_out, result_valid && !inside_res, pixel_index == '0)
    `NGPI_ASSERT_IMP(a_never_busy, start, !busy)
endmodule

// File: hw/rtl/ngpi_div_cell.sv
// one restoring division cell: two quotient bits of both axes per cell
module ngpi_div_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      vld_in,
    input  logic [ngpi_pkg::NUM_W-1:0] rx_in,
    input  logic [ngpi_pkg::NUM_W-1:0] ry_in,
    input  logic [ngpi_pkg::QW-1:0]    qx_in,
    input  logic [ngpi_pkg::QW-1:0]    qy_in,
    input  logic [ngpi_pkg::DEN_W-1:0] dx_in,
    input  logic [ngpi_pkg::DEN_W-1:0] dy_in,
    input  logic                      nx_in,
    input  logic                      ny_in,
    input  ngpi_pkg::side_t           side_in,
    output logic                      vld_out,
    output logic [ngpi_pkg::NUM_W-1:0] rx_out,
    output logic [ngpi_pkg::NUM_W-1:0] ry_out,
    output logic [ngpi_pkg::QW-1:0]    qx_out,
    output logic [ngpi_pkg::QW-1:0]    qy_out,
    output logic [ngpi_pkg::DEN_W-1:0] dx_out,
    output logic [ngpi_pkg::DEN_W-1:0] dy_out,
    output logic                      nx_out,
    output logic                      ny_out,
    output ngpi_pkg::side_t           side_out
);
    import ngpi_pkg::*;

    localparam int unsigned RW = DEN_W + 1;

    logic              vld_reg;
    logic [NUM_W-1:0]  rx_reg, ry_reg, rx_next, ry_next;
    logic [QW-1:0]     qx_reg, qy_reg, qx_next, qy_next;
    logic [DEN_W-1:0]  dx_reg, dy_reg;
    logic              nx_reg, ny_reg;
    side_t             side_reg;

    // two restoring steps: the numerator word shifts into the remainder msb first
    // and each quotient bit enters at its bottom
    function automatic logic [NUM_W+QW-1:0] two_steps(
        input logic [NUM_W-1:0] r, input logic [QW-1:0] q,
        input logic [DEN_W-1:0] d);
        logic [NUM_W-1:0] rr;
        logic [QW-1:0]    qq;
        logic [RW-1:0]    sh;
        logic [RW:0]      t;
        int               k;
        rr = r;
        qq = q;
        for (k = 0; k < 2; k++)
        begin
            sh = {rr[DEN_W-1:0], qq[QW-1]};
            t  = {1'b0, sh} - {2'b00, d};
            qq = {qq[QW-2:0], ~t[RW]};
            if (!t[RW])
                rr = NUM_W'(t[RW-1:0]);
            else
                rr = NUM_W'(sh);
        end
        return {rr, qq};
    endfunction

    always_comb
    begin
        {rx_next, qx_next} = two_steps(rx_in, qx_in, dx_in);
        {ry_next, qy_next} = two_steps(ry_in, qy_in, dy_in);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
        dx_reg   <= dx_in;
        dy_reg   <= dy_in;
        nx_reg   <= nx_in;
        ny_reg   <= ny_in;
        side_reg <= side_in;
    end

    assign vld_out  = vld_reg;
    assign rx_out   = rx_reg;
    assign ry_out   = ry_reg;
    assign qx_out   = qx_reg;
    assign qy_out   = qy_reg;
    assign dx_out   = dx_reg;
    assign dy_out   = dy_reg;
    assign nx_out   = nx_reg;
    assign ny_out   = ny_reg;
    assign side_out = side_reg;
endmodule
